>>> rtl/core/ilb_pkg.sv
// Shared constants, codes and record type of the indexed list buffer.
package ilb_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POS_W   = 4;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W + 1;
    localparam int OCNT_W  = 5;
    localparam int REC_W   = 19;
    localparam int IN_W    = 24;
    localparam int OUT_W   = 32;
    localparam int REQ_W   = 3;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_BACK   = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_INSERT     = 3'd4,
        REQ_REMOVE     = 3'd5,
        REQ_READ       = 3'd6,
        REQ_CLEAR      = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [6:0] pct;
        logic [3:0] kind;
        logic [7:0] fac;
    } rec_t;

endpackage

>>> rtl/core/indexed_list_buffer.sv
// Indexed list buffer: a bounded ordered list of records held in one memory.
//
// The block keeps up to DEPTH records of 19 bits in a single synchronous
// memory with one write port and one read port whose data arrives in the cycle
// after the address. Each input word carries one request: push to the back
// or the front, pop from the back or the front, insert or remove at an
// index, read at an index, or clear. Every request yields exactly one output
// word with the affected record, a status and the entry count after the
// request. One request is worked on at a time, and the input side is ready
// only while the sequencer is idle; a finished word sits in the output
// register so the next request can start while it waits to be taken. While
// an earlier word is still untaken, the sequencer waits in its last state,
// and the input stays stalled, until the output register frees up. A push
// to the back, a clear and any failed request go straight from idle to the
// output state; a read and a pop from the back pass through the read state
// first. Insert, push to the front, remove and pop from the front move every
// later entry by one place, one entry per cycle through the single write
// port; an insert or a push to the front then writes the new record in its
// slot. At most DEPTH - 1 entries move. Entries are not cleared at reset;
// only entries below the count are ever read. A failed request leaves the
// list as it was and returns zero record fields.
module indexed_list_buffer
    import ilb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    // Fields from bit 0: position[3:0], in_faculty[11:4], in_stick_type[15:12],
    // in_percentage[22:16], zero pad[23].
    input  logic [IN_W-1:0]   s_tdata,
    // Fields from bit 0: req_type[2:0].
    input  logic [REQ_W-1:0]  s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // Fields from bit 0: out_faculty[7:0], out_stick_type[11:8],
    // out_percentage[18:12], status[20:19], entry_count[25:21], zero pad[31:26].
    output logic [OUT_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_UP,
        S_FIN,
        S_DOWN,
        S_OUT
    } state_t;

    // Record memory.
    rec_t             mem [DEPTH];
    rec_t             mem_rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    rec_t             mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    // Sequencer state.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              first_reg, first_next;
    rec_t              res_rec_reg, res_rec_next;
    status_t           res_status_reg, res_status_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]  m_data_reg, m_data_next;

    // Decoded input word.
    req_t              in_req;
    logic [POS_W-1:0]  in_pos;
    rec_t              in_rec;
    logic              accept;
    logic              out_free;
    logic              full;
    logic              empty;
    logic              pos_bad;

    assign in_req   = req_t'(s_tuser);
    assign in_pos   = s_tdata[3:0];
    assign in_rec   = rec_t'(s_tdata[22:4]);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    // The position is compared at a width that holds both it and the count.
    assign pos_bad  = (CMP_W'(in_pos) >= CMP_W'(count_reg));

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        pos_next        = pos_reg;
        first_next      = first_reg;
        res_rec_next    = res_rec_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = in_rec;
        mem_raddr       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_rec_next    = '0;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                    unique case (in_req)
                        REQ_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = count_reg[IDX_W-1:0];
                                mem_wdata    = in_rec;
                                count_next   = count_reg + 1'b1;
                                res_rec_next = in_rec;
                            end
                        end
                        REQ_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                res_rec_next = in_rec;
                                pos_next     = '0;
                                if (empty)
                                begin
                                    mem_we    = 1'b1;
                                    mem_waddr = '0;
                                    mem_wdata = in_rec;
                                end
                                else
                                begin
                                    mem_raddr  = IDX_W'(count_reg - 1'b1);
                                    ptr_next   = count_reg;
                                    state_next = S_UP;
                                end
                            end
                        end
                        REQ_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_raddr  = IDX_W'(count_reg - 1'b1);
                                state_next = S_RD;
                            end
                        end
                        REQ_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                first_next = 1'b1;
                                state_next = S_DOWN;
                            end
                        end
                        REQ_INSERT:
                        begin
                            // The index is checked before the fill level.
                            if (pos_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                count_next   = count_reg + 1'b1;
                                res_rec_next = in_rec;
                                pos_next     = CNT_W'(in_pos);
                                mem_raddr    = IDX_W'(count_reg - 1'b1);
                                ptr_next     = count_reg;
                                state_next   = S_UP;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                                mem_raddr  = IDX_W'(in_pos);
                                ptr_next   = CNT_W'(in_pos);
                                first_next = 1'b1;
                                state_next = S_DOWN;
                            end
                        end
                        REQ_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                mem_raddr  = IDX_W'(in_pos);
                                state_next = S_RD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                res_rec_next = mem_rdata_reg;
                state_next   = S_OUT;
            end
            S_UP:
            begin
                // The entry below ptr arrives now and moves up one place.
                mem_we    = 1'b1;
                mem_waddr = ptr_reg[IDX_W-1:0];
                mem_wdata = mem_rdata_reg;
                if ((ptr_reg - 1'b1) > pos_reg)
                begin
                    mem_raddr = IDX_W'(ptr_reg - 2'd2);
                    ptr_next  = ptr_reg - 1'b1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg[IDX_W-1:0];
                mem_wdata  = res_rec_reg;
                state_next = S_OUT;
            end
            S_DOWN:
            begin
                // The first read returns the removed record; later reads move
                // down one place. The count already holds its new value.
                first_next = 1'b0;
                if (first_reg)
                begin
                    res_rec_next = mem_rdata_reg;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(ptr_reg - 1'b1);
                    mem_wdata = mem_rdata_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    mem_raddr = IDX_W'(ptr_reg + 1'b1);
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{(OUT_W - REC_W - 2 - OCNT_W){1'b0}},
                                    OCNT_W'(count_reg), res_status_reg, res_rec_reg};
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        pos_reg        <= pos_next;
        res_rec_reg    <= res_rec_next;
        res_status_reg <= res_status_next;
        m_data_reg     <= m_data_next;
    end

    // The count never passes the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    // Moves and the final insert write only inside the held range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != S_IDLE) |-> (CNT_W'(mem_waddr) < count_reg))
        else $error("shift write outside the held entries");

    // A full status always reports a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_data_reg[REC_W +: 2] == ST_FULL)
            |-> (m_data_reg[REC_W + 2 +: OCNT_W] == OCNT_W'(DEPTH)))
        else $error("full status with a list that is not full");

endmodule

>>> verif/indexed_list_buffer_test.sv
// Self-checking testbench for the indexed list buffer with its own list predictor.
`timescale 1ns / 100ps

module indexed_list_buffer_test;
    import ilb_pkg::*;

    // Hard stop for a hung run, far beyond the slowest correct run.
    localparam int LIMIT_NS      = 5_000_000;
    // Number of random requests in the main traffic test.
    localparam int RANDOM_WORDS  = 600;
    // The last stretch of the random traffic runs with no idling at all.
    localparam int STEADY_WORDS  = 100;
    // Length of the long receiver hold that backs the block up.
    localparam int LONG_HOLD     = 250;

    // One predicted output word, kept as separate fields.
    typedef struct {
        rec_t                 rec;
        status_t              st;
        logic [OCNT_W-1:0]    count;
    } list_outcome_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    // Fields from bit 0: position[3:0], in_faculty[11:4], in_stick_type[15:12],
    // in_percentage[22:16], zero pad[23].
    logic [IN_W-1:0]   s_tdata = '0;
    // Fields from bit 0: req_type[2:0].
    logic [REQ_W-1:0]  s_tuser = REQ_CLEAR;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    // Fields from bit 0: out_faculty[7:0], out_stick_type[11:8],
    // out_percentage[18:12], status[20:19], entry_count[25:21], zero pad[31:26].
    logic [OUT_W-1:0]  m_tdata;

    // Predictor state: the list contents and the number of entries held.
    rec_t              model_entries [DEPTH];
    int unsigned       model_len = 0;

    // Predicted output words, oldest first, in the order requests were taken.
    list_outcome_t     pending_outcomes [$];

    int                mismatch_count = 0;

    // When set, neither side inserts random idle cycles.
    bit                steady_tail = 1'b0;
    // A nonzero value asks the receiver to hold off; the value sets the hold's length.
    int                hold_request = 0;

    indexed_list_buffer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor. Applies one request to the list copy and returns the word
    // the block must answer with. A failed request leaves the list alone
    // and answers with zero record fields, as a clear does too.
    // ------------------------------------------------------------------
    function automatic list_outcome_t list_apply(req_t op, logic [POS_W-1:0] pos, rec_t rec);
        list_outcome_t res;
        int unsigned at;
        at = pos;
        res.rec = '0;
        res.st = ST_OK;
        case (op)
            REQ_PUSH_BACK:
                if (model_len >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    model_entries[model_len] = rec;
                    model_len++;
                    res.rec = rec;
                end
            REQ_PUSH_FRONT:
                if (model_len >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    for (int k = model_len; k > 0; k--)
                        model_entries[k] = model_entries[k-1];
                    model_entries[0] = rec;
                    model_len++;
                    res.rec = rec;
                end
            REQ_POP_BACK:
                if (model_len == 0)
                    res.st = ST_RANGE;
                else
                begin
                    model_len--;
                    res.rec = model_entries[model_len];
                end
            REQ_POP_FRONT:
                if (model_len == 0)
                    res.st = ST_RANGE;
                else
                begin
                    res.rec = model_entries[0];
                    for (int k = 1; k < model_len; k++)
                        model_entries[k-1] = model_entries[k];
                    model_len--;
                end
            REQ_INSERT:
                // The index is checked before fullness, so an insert into an
                // empty list is always out of range.
                if (at >= model_len)
                    res.st = ST_RANGE;
                else if (model_len >= DEPTH)
                    res.st = ST_FULL;
                else
                begin
                    for (int k = model_len; k > at; k--)
                        model_entries[k] = model_entries[k-1];
                    model_entries[at] = rec;
                    model_len++;
                    res.rec = rec;
                end
            REQ_REMOVE:
                if (at >= model_len)
                    res.st = ST_RANGE;
                else
                begin
                    res.rec = model_entries[at];
                    for (int k = at + 1; k < model_len; k++)
                        model_entries[k-1] = model_entries[k];
                    model_len--;
                end
            REQ_READ:
                if (at >= model_len)
                    res.st = ST_RANGE;
                else
                    res.rec = model_entries[at];
            default:
                // Clear empties the list and always succeeds.
                model_len = 0;
        endcase
        res.count = OCNT_W'(model_len);
        return res;
    endfunction

    function automatic rec_t make_record(logic [7:0] fac, logic [3:0] kind, logic [6:0] pct);
        rec_t r;
        r.fac = fac;
        r.kind = kind;
        r.pct = pct;
        return r;
    endfunction

    // Percentages are mostly legal, but values above 100 must pass through
    // untouched, so the upper codes show up too.
    function automatic rec_t random_record();
        rec_t r;
        r.fac = 8'($urandom);
        r.kind = 4'($urandom);
        if ($urandom_range(0, 7) == 0)
            r.pct = 7'($urandom_range(101, 127));
        else
            r.pct = 7'($urandom_range(0, 100));
        return r;
    endfunction

    task automatic note_failure(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Sender. Offers one request word, holds it until the block takes it and
    // predicts at the accepting edge. tvalid then stays high, so back-to-back
    // words need no dead cycle, but outside the steady tail it may drop for a
    // random idle stretch; callers that stop sending use wait_for_results, which lowers it.
    // ------------------------------------------------------------------
    task automatic send_request(req_t op, logic [POS_W-1:0] pos, rec_t rec);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {1'b0, rec.pct, rec.kind, rec.fac, pos};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_outcomes.insert(pending_outcomes.size(), list_apply(op, pos, rec));
        if (!steady_tail && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    // Stops offering words and waits until every predicted word has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver. Checks every word taken from the block against the oldest
    // prediction and decides tready for the next cycle: a long hold when a
    // test asks for one, otherwise occasional random stalls outside the steady tail.
    // ------------------------------------------------------------------
    task automatic check_word(logic [OUT_W-1:0] word);
        list_outcome_t want;
        rec_t got_rec;
        status_t got_st;
        logic [OCNT_W-1:0] got_count;
        if (pending_outcomes.size() == 0)
        begin
            note_failure($sformatf("output word %h with no request outstanding", word));
            return;
        end
        want = pending_outcomes[0];
        pending_outcomes.delete(0);
        got_rec = word[REC_W-1:0];
        got_st = status_t'(word[20:19]);
        got_count = word[25:21];
        if (got_rec.fac !== want.rec.fac || got_rec.kind !== want.rec.kind
            || got_rec.pct !== want.rec.pct || got_st !== want.st
            || got_count !== want.count)
            note_failure($sformatf(
                "expected fac %h kind %h pct %0d status %s count %0d, got fac %h kind %h pct %0d status %0d count %0d",
                want.rec.fac, want.rec.kind, want.rec.pct, want.st.name(), want.count,
                got_rec.fac, got_rec.kind, got_rec.pct, word[20:19], got_count));
    endtask

    int hold_left = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_word(m_tdata);
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rst_n && !steady_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Each request but the pushes against an empty list: all of pop, remove, read and
    // insert must fail as out of range, and clear must still succeed.
    task automatic test_empty_list();
        send_request(REQ_READ, 4'd0, random_record());
        send_request(REQ_POP_BACK, 4'd0, random_record());
        send_request(REQ_POP_FRONT, 4'd15, random_record());
        send_request(REQ_REMOVE, 4'd0, random_record());
        send_request(REQ_INSERT, 4'd0, random_record());
        send_request(REQ_CLEAR, 4'd15, random_record());
    endtask

    // Records at the extremes of every field, including a percentage above
    // 100, moved through each kind of request but clear on a short list.
    task automatic test_record_extremes();
        send_request(REQ_PUSH_BACK, 4'd15, make_record(8'hFF, 4'hF, 7'd127));
        send_request(REQ_PUSH_FRONT, 4'd0, make_record(8'h00, 4'h0, 7'd0));
        send_request(REQ_INSERT, 4'd1, make_record(8'hA5, 4'h5, 7'd100));
        send_request(REQ_INSERT, 4'd0, make_record(8'h5A, 4'hA, 7'd101));
        send_request(REQ_READ, 4'd0, random_record());
        send_request(REQ_READ, 4'd3, random_record());
        send_request(REQ_READ, 4'd4, random_record());
        send_request(REQ_READ, 4'd15, random_record());
        send_request(REQ_REMOVE, 4'd2, random_record());
        send_request(REQ_INSERT, 4'd3, random_record());
        send_request(REQ_POP_FRONT, 4'd0, random_record());
        send_request(REQ_POP_BACK, 4'd0, random_record());
        send_request(REQ_REMOVE, 4'd0, random_record());
        send_request(REQ_POP_BACK, 4'd0, random_record());
        send_request(REQ_POP_FRONT, 4'd0, random_record());
    endtask

    // The receiver holds off for a long stretch while pushes keep coming,
    // so the block backs up and stalls its input. The pushes run the list
    // past full, then the full-list cases are exercised once it drains.
    task automatic test_full_list_and_backpressure();
        wait_for_results();
        hold_request = LONG_HOLD;
        for (int n = 0; n < DEPTH + 4; n++)
            send_request(($urandom_range(0, 1) == 0) ? REQ_PUSH_BACK : REQ_PUSH_FRONT,
                         4'($urandom), random_record());
        send_request(REQ_INSERT, 4'd15, random_record());
        send_request(REQ_INSERT, 4'd0, random_record());
        send_request(REQ_READ, 4'd15, random_record());
        send_request(REQ_REMOVE, 4'd15, random_record());
        send_request(REQ_INSERT, 4'd14, random_record());
        send_request(REQ_POP_FRONT, 4'd0, random_record());
        send_request(REQ_PUSH_FRONT, 4'd0, random_record());
        send_request(REQ_CLEAR, 4'd0, random_record());
        send_request(REQ_READ, 4'd0, random_record());
        // The sender now waits until every result is back before going on.
        wait_for_results();
    endtask

    // Mostly well-formed traffic: indices below the current length, in
    // phases that favor growth, shrinkage or a balance, so the list swings
    // between empty and full. A tenth of the words are fully random.
    task automatic test_random_traffic();
        int phase;
        int roll;
        req_t op;
        logic [POS_W-1:0] pos;
        phase = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 60 == 0)
                phase = $urandom_range(0, 2);
            if (n == RANDOM_WORDS - STEADY_WORDS)
                steady_tail = 1'b1;
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                op = req_t'($urandom_range(0, 7));
            else if (roll < ((phase == 0) ? 70 : (phase == 1) ? 20 : 45))
            begin
                case ($urandom_range(0, 2))
                    0: op = REQ_PUSH_BACK;
                    1: op = REQ_PUSH_FRONT;
                    default: op = REQ_INSERT;
                endcase
            end
            else if (roll < 99)
            begin
                case ($urandom_range(0, 3))
                    0: op = REQ_POP_BACK;
                    1: op = REQ_POP_FRONT;
                    2: op = REQ_REMOVE;
                    default: op = REQ_READ;
                endcase
            end
            else
                op = REQ_CLEAR;
            if (model_len != 0 && $urandom_range(0, 9) != 0)
                pos = POS_W'($urandom_range(0, model_len - 1));
            else
                pos = POS_W'($urandom);
            send_request(op, pos, random_record());
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_record_extremes();
        test_full_list_and_backpressure();
        test_random_traffic();

        // Drain, then give the block time to show any stray word.
        wait_for_results();
        repeat (DEPTH + 8)
            @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("[indexed_list_buffer] OK");
        else
            $display("[indexed_list_buffer] ERROR");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS * 1ns);
        $display("[indexed_list_buffer] ERROR");
        $finish;
    end

endmodule

>>> indexed_list_buffer.f
rtl/core/ilb_pkg.sv
rtl/core/indexed_list_buffer.sv
verif/indexed_list_buffer_test.sv
